### src/bff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bff_pkg;

   // Bit store geometry
   localparam int FILTER_BITS = 1024;
   localparam int BIT_ADDR_W  = $clog2(FILTER_BITS);
   localparam int HASH_W      = BIT_ADDR_W;
   localparam int M_W         = BIT_ADDR_W + 1;

   // Operand of the reducer: HASH_W x 8 product plus an addend, rounded to even bits
   localparam int OPERAND_W    = ((HASH_W + 10) / 2) * 2;
   localparam int REDUCE_STEPS = OPERAND_W / 2;
   localparam int STEP_CNT_W   = $clog2(REDUCE_STEPS + 1);

   // Hash constants
   localparam logic [7:0] K_MULT37 = 8'd37;
   localparam logic [7:0] K_ONE    = 8'd1;
   localparam logic [7:0] K_POW17  = 8'd17;
   localparam logic [7:0] K_POW11  = 8'd11;

   localparam logic [HASH_W-1:0] H_MULT37_START  = HASH_W'(8);
   localparam logic [HASH_W-1:0] H_SUM_START     = HASH_W'(0);
   localparam logic [HASH_W-1:0] H_POW17_START   = HASH_W'(1);
   localparam logic [HASH_W-1:0] H_FIRST11_START = HASH_W'(4);
   localparam logic [HASH_W-1:0] POW_START       = HASH_W'(1);

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic             REG_FILTER_SIZE   = 1'b0;
   localparam logic [M_W-1:0]   FILTER_SIZE_RESET = M_W'(FILTER_BITS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_REDUCE,
      ST_READ,
      ST_WRITE,
      ST_RESULT
   } st_type;

   typedef enum logic [2:0] {
      OP_MULT37,
      OP_SUM,
      OP_POW17_HASH,
      OP_FIRST11,
      OP_POW17,
      OP_POW11
   } op_type;

   typedef struct packed {
      logic                  done;
      logic [HASH_W-1:0]     result;
   } red_status_type;

   typedef struct packed {
      logic                  we;
      logic [BIT_ADDR_W-1:0] waddr;
      logic                  wdata;
      logic [BIT_ADDR_W-1:0] raddr;
   } store_req_type;

endpackage

`default_nettype wire

### src/bloom_filter_four_hash.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-hash Bloom filter over a 1024-bit store. A key streams in one byte per transaction
// and tlast marks its final byte; tuser on that byte picks insert (1) or lookup (0). Each
// byte updates six modular values (four hashes, two powers) through one shared radix-4
// reducer, one value after another, and no new byte is taken until all six are done. The
// final byte adds the store reads, writes of the four probed bits on an insert that finds
// one clear, and the posting of the result. A result sits in an output register, so the
// next key may start before it is taken. After reset the store is swept to zero, one bit
// per cycle, before the first byte is accepted; configuration writes are taken during the
// sweep. filter_size (word 0) sets the modulus; 0 acts as 1 and values above 1024 act as
// 1024.
module bloom_filter_four_hash
   import bff_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: tdata[7:0] character; tuser[0] kind; tlast last
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,
   input  wire logic [0:0]            req_tuser,
   input  wire logic                  req_tlast,
   // response: tdata[0] answer, tdata[7:1] zero; tuser[0] was_insert
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic [0:0]                 rsp_tuser,
   // configuration
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   st_type              state_ff, state_in;
   op_type              op_ff, op_in;
   logic [HASH_W-1:0]   h_mult37_ff, h_mult37_in;
   logic [HASH_W-1:0]   h_sum_ff, h_sum_in;
   logic [HASH_W-1:0]   h_pow17_ff, h_pow17_in;
   logic [HASH_W-1:0]   h_first11_ff, h_first11_in;
   logic [HASH_W-1:0]   pow17_ff, pow17_in;
   logic [HASH_W-1:0]   pow11_ff, pow11_in;
   logic [7:0]          first_ff, first_in;
   logic                at_start_ff, at_start_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;
   logic                kind_ff, kind_in;
   logic [2:0]          seq_cnt_ff, seq_cnt_in;
   logic                all_set_ff, all_set_in;
   logic [BIT_ADDR_W-1:0] clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_answer_ff, rsp_answer_in;
   logic                rsp_insert_ff, rsp_insert_in;
   logic [M_W-1:0]      filter_size_ff, filter_size_in;

   logic                  csr_write;
   logic [M_W-1:0]        modulus;
   logic                  red_start;
   logic [OPERAND_W-1:0]  operand;
   red_status_type        red_status;
   store_req_type         store_req;
   logic                  store_rdata;
   logic [HASH_W-1:0]     op_a;
   logic [7:0]            op_b;
   logic [OPERAND_W-1:0]  op_e;
   logic [HASH_W+7:0]     op_prod;
   logic [BIT_ADDR_W-1:0] probe_idx;
   logic                  req_accept;
   logic                  probe_bit;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign filter_size_in = (csr_write && csr_paddr[2] == REG_FILTER_SIZE)
                         ? csr_pwdata[M_W-1:0] : filter_size_ff;
   assign csr_prdata = (csr_paddr[2] == REG_FILTER_SIZE)
                     ? CSR_DATA_W'(filter_size_ff) : '0;

   // Clamp the modulus to 1..FILTER_BITS
   always_comb begin
      if (filter_size_ff == '0) begin
         modulus = M_W'(1);
      end else if (filter_size_ff > M_W'(FILTER_BITS)) begin
         modulus = M_W'(FILTER_BITS);
      end else begin
         modulus = filter_size_ff;
      end
   end

   // Form the reducer operand a*b + e for the current update
   always_comb begin
      op_a = h_mult37_ff;
      op_b = K_MULT37;
      op_e = OPERAND_W'(char_ff);
      unique case (op_ff)
         OP_MULT37: begin
            op_a = h_mult37_ff;
            op_b = K_MULT37;
            op_e = OPERAND_W'(char_ff);
         end
         OP_SUM: begin
            op_a = h_sum_ff;
            op_b = K_ONE;
            op_e = OPERAND_W'(char_ff);
         end
         OP_POW17_HASH: begin
            op_a = pow17_ff;
            op_b = char_ff;
            op_e = OPERAND_W'(h_pow17_ff);
         end
         OP_FIRST11: begin
            // nine times the hash as a shift and add
            op_a = pow11_ff;
            op_b = first_ff;
            op_e = (OPERAND_W'(h_first11_ff) << 3) + OPERAND_W'(h_first11_ff);
         end
         OP_POW17: begin
            op_a = pow17_ff;
            op_b = K_POW17;
            op_e = '0;
         end
         OP_POW11: begin
            op_a = pow11_ff;
            op_b = K_POW11;
            op_e = '0;
         end
         default: begin
            op_a = '0;
            op_b = '0;
            op_e = '0;
         end
      endcase
      op_prod = op_a * op_b;
      operand = OPERAND_W'(op_prod) + op_e;
   end

   // Pick the hash that indexes the store for this probe
   always_comb begin
      case (seq_cnt_ff[1:0])
         2'd0:    probe_idx = BIT_ADDR_W'(h_mult37_ff);
         2'd1:    probe_idx = BIT_ADDR_W'(h_sum_ff);
         2'd2:    probe_idx = BIT_ADDR_W'(h_pow17_ff);
         default: probe_idx = BIT_ADDR_W'(h_first11_ff);
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      h_mult37_in   = h_mult37_ff;
      h_sum_in      = h_sum_ff;
      h_pow17_in    = h_pow17_ff;
      h_first11_in  = h_first11_ff;
      pow17_in      = pow17_ff;
      pow11_in      = pow11_ff;
      first_in      = first_ff;
      at_start_in   = at_start_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      kind_in       = kind_ff;
      seq_cnt_in    = seq_cnt_ff;
      all_set_in    = all_set_ff;
      clr_in        = clr_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_insert_in = rsp_insert_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      red_start     = 1'b0;
      probe_bit     = 1'b1;
      store_req.we    = 1'b0;
      store_req.waddr = probe_idx;
      store_req.wdata = 1'b1;
      store_req.raddr = probe_idx;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the store to zero after reset
            store_req.we    = 1'b1;
            store_req.waddr = clr_ff;
            store_req.wdata = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BIT_ADDR_W'(FILTER_BITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               char_in = req_tdata;
               last_in = req_tlast;
               kind_in = req_tuser[0];
               if (at_start_ff) begin
                  first_in    = req_tdata;
                  at_start_in = 1'b0;
               end
               op_in    = OP_MULT37;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            red_start = 1'b1;
            state_in  = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (red_status.done) begin
               state_in = ST_LOAD;
               unique case (op_ff)
                  OP_MULT37: begin
                     h_mult37_in = red_status.result;
                     op_in = OP_SUM;
                  end
                  OP_SUM: begin
                     h_sum_in = red_status.result;
                     op_in = OP_POW17_HASH;
                  end
                  OP_POW17_HASH: begin
                     h_pow17_in = red_status.result;
                     op_in = OP_FIRST11;
                  end
                  OP_FIRST11: begin
                     h_first11_in = red_status.result;
                     op_in = OP_POW17;
                  end
                  OP_POW17: begin
                     pow17_in = red_status.result;
                     op_in = OP_POW11;
                  end
                  OP_POW11: begin
                     pow11_in   = red_status.result;
                     seq_cnt_in = '0;
                     all_set_in = 1'b1;
                     state_in   = last_ff ? ST_READ : ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            // probe four bits; read data is registered and arrives in the cycle after its address
            if (seq_cnt_ff != 3'd0) begin
               probe_bit = store_rdata;
            end
            all_set_in = all_set_ff & probe_bit;
            seq_cnt_in = seq_cnt_ff + 1'b1;
            if (seq_cnt_ff == 3'd4) begin
               seq_cnt_in = '0;
               state_in   = (kind_ff && !all_set_in) ? ST_WRITE : ST_RESULT;
            end
         end
         ST_WRITE: begin
            store_req.we = 1'b1;
            seq_cnt_in   = seq_cnt_ff + 1'b1;
            if (seq_cnt_ff == 3'd3) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // post the result once the output register is free, then restart the key
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = kind_ff ? ~all_set_ff : all_set_ff;
               rsp_insert_in = kind_ff;
               h_mult37_in   = H_MULT37_START;
               h_sum_in      = H_SUM_START;
               h_pow17_in    = H_POW17_START;
               h_first11_in  = H_FIRST11_START;
               pow17_in      = POW_START;
               pow11_in      = POW_START;
               at_start_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         filter_size_ff <= FILTER_SIZE_RESET;
         h_mult37_ff    <= H_MULT37_START;
         h_sum_ff       <= H_SUM_START;
         h_pow17_ff     <= H_POW17_START;
         h_first11_ff   <= H_FIRST11_START;
         pow17_ff       <= POW_START;
         pow11_ff       <= POW_START;
         first_ff       <= '0;
         at_start_ff    <= 1'b1;
         op_ff          <= OP_MULT37;
         seq_cnt_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         filter_size_ff <= filter_size_in;
         h_mult37_ff    <= h_mult37_in;
         h_sum_ff       <= h_sum_in;
         h_pow17_ff     <= h_pow17_in;
         h_first11_ff   <= h_first11_in;
         pow17_ff       <= pow17_in;
         pow11_ff       <= pow11_in;
         first_ff       <= first_in;
         at_start_ff    <= at_start_in;
         op_ff          <= op_in;
         seq_cnt_ff     <= seq_cnt_in;
      end
      char_ff       <= char_in;
      last_ff       <= last_in;
      kind_ff       <= kind_in;
      all_set_ff    <= all_set_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_insert_ff <= rsp_insert_in;
   end

   bff_reducer u_reducer (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .operand (operand),
      .modulus (modulus),
      .status  (red_status)
   );

   bff_bit_store u_bit_store (
      .clock (clock),
      .req   (store_req),
      .rdata (store_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_answer_ff};
   assign rsp_tuser  = rsp_insert_ff;

endmodule

`default_nettype wire

### src/bff_reducer.sv
`timescale 1ns / 1ps
`default_nettype none

// Radix-4 restoring reduction: operand mod modulus, two bits per cycle
module bff_reducer
   import bff_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [OPERAND_W-1:0] operand,
   input  wire logic [M_W-1:0]       modulus,
   output red_status_type            status
);

   logic [OPERAND_W-1:0]  x_ff, x_in;
   logic [HASH_W-1:0]     r_ff, r_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  done_ff, done_in;

   logic [M_W+1:0] t, m1, m2, m3;

   // Shift two operand bits into the remainder and take off 0..3 times the modulus
   always_comb begin
      x_in    = x_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      t  = (M_W+2)'({r_ff, x_ff[OPERAND_W-1 -: 2]});
      m1 = (M_W+2)'(modulus);
      m2 = m1 << 1;
      m3 = m2 + m1;
      if (start) begin
         x_in   = operand;
         r_in   = '0;
         cnt_in = STEP_CNT_W'(REDUCE_STEPS);
      end else if (cnt_ff != '0) begin
         x_in   = x_ff << 2;
         cnt_in = cnt_ff - 1'b1;
         if (t >= m3) begin
            r_in = HASH_W'(t - m3);
         end else if (t >= m2) begin
            r_in = HASH_W'(t - m2);
         end else if (t >= m1) begin
            r_in = HASH_W'(t - m1);
         end else begin
            r_in = HASH_W'(t);
         end
         done_in = (cnt_ff == STEP_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      r_ff <= r_in;
   end

   assign status.done   = done_ff;
   assign status.result = r_ff;

endmodule

`default_nettype wire

### src/bff_bit_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-bit store: one write port, one registered read port
module bff_bit_store
   import bff_pkg::*;
(
   input  wire logic    clock,
   input  store_req_type req,
   output logic         rdata
);

   logic mem_ff [FILTER_BITS];
   logic rdata_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[req.waddr] <= req.wdata;
      end
      rdata_ff <= mem_ff[req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### src/bff_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bff_checker
   import bff_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [7:0]            req_tdata,
   input wire logic [0:0]            req_tuser,
   input wire logic                  req_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [7:0]            rsp_tdata,
   input wire logic [0:0]            rsp_tuser,
   input wire logic                  csr_psel,
   input wire logic                  csr_penable,
   input wire logic                  csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [CSR_DATA_W-1:0] csr_prdata,
   input wire logic                  csr_pready
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // The store sweep keeps the input closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input ready during store sweep");

   // A byte occupies the block for the following cycles
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("input ready right after a byte was taken");

   // No byte, whether or not it ends a key, posts a result right away
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result posted right after a byte");

endmodule

bind bloom_filter_four_hash bff_checker u_bff_checker (.*);

`default_nettype wire
